// ===== src/cam_pkg.sv =====
// ----------------------------------------------------------------------------
// cam_pkg
// Shared constants, types and helpers of the calibrated ADC averaging block.
// ----------------------------------------------------------------------------
package cam_pkg;

   localparam int RAW_W      = 12;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int OUT_W      = 19;
   localparam int MUL_W      = 18;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int BASE_W     = 17;
   localparam int RAW_SHIFT  = 12;
   localparam int GAIN_SHIFT = 14;
   localparam int CAL_W      = PROD_W - GAIN_SHIFT;

   localparam int FULL_SCALE = 66000;
   localparam int MID_SCALE  = 33000;

   localparam int DEFAULT_WINDOW_LENGTH = 16;

   localparam logic [CSR_W-1:0] GAIN_RESET   = 16'd16384;
   localparam logic [CSR_W-1:0] OFFSET_RESET = 16'd0;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURRENT_GAIN   = 3'd0,
      CSR_VOLTAGE_GAIN   = 3'd1,
      CSR_CURRENT_OFFSET = 3'd2,
      CSR_VOLTAGE_OFFSET = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STEP_CBASE,
      STEP_VBASE,
      STEP_CGAIN,
      STEP_VGAIN
   } calc_step_type;

   typedef struct packed {
      logic          en;
      calc_step_type step;
   } calc_ctrl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } win_ctrl_type;

   function automatic logic signed [OUT_W-1:0] saturate(input logic signed [CAL_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > CAL_W'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (v < CAL_W'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/cam_req_if.sv =====
// ----------------------------------------------------------------------------
// cam_req_if
// Input channel: one pair of raw converter codes per transfer.
// ----------------------------------------------------------------------------
interface cam_req_if;
   logic                        valid;
   logic                        ready;
   logic [cam_pkg::RAW_W-1:0]   current_raw;
   logic [cam_pkg::RAW_W-1:0]   voltage_raw;

   modport source (output valid, output current_raw, output voltage_raw, input ready);
   modport sink   (input valid, input current_raw, input voltage_raw, output ready);
endinterface

// ===== src/cam_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cam_rsp_if
// Result channel: calibrated current, voltage and averaged current.
// ----------------------------------------------------------------------------
interface cam_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cam_pkg::OUT_W-1:0]   current_scaled;
   logic signed [cam_pkg::OUT_W-1:0]   voltage_scaled;
   logic signed [cam_pkg::OUT_W-1:0]   current_filtered;

   modport source (output valid, output current_scaled, output voltage_scaled,
                   output current_filtered, input ready);
   modport sink   (input valid, input current_scaled, input voltage_scaled,
                   input current_filtered, output ready);
endinterface

// ===== src/cam_calib.sv =====
// ----------------------------------------------------------------------------
// cam_calib
// Shared 18x18 multiplier: converts codes to base values, then applies gain,
// offset and saturation, one multiply per step.
// ----------------------------------------------------------------------------
module cam_calib (
   input  logic                                  clock,
   input  cam_pkg::calc_ctrl_type                ctrl,
   input  logic [cam_pkg::RAW_W-1:0]             current_raw,
   input  logic [cam_pkg::RAW_W-1:0]             voltage_raw,
   input  logic [cam_pkg::CSR_W-1:0]             current_gain,
   input  logic [cam_pkg::CSR_W-1:0]             voltage_gain,
   input  logic signed [cam_pkg::CSR_W-1:0]      current_offset,
   input  logic signed [cam_pkg::CSR_W-1:0]      voltage_offset,
   output logic signed [cam_pkg::OUT_W-1:0]      cal_value,
   output logic signed [cam_pkg::OUT_W-1:0]      current_ff
);
   import cam_pkg::*;

   logic [RAW_W-1:0]          vraw_ff;
   logic signed [MUL_W-1:0]   cbase_ff;
   logic signed [MUL_W-1:0]   vbase_ff;

   logic signed [MUL_W-1:0]   op_a;
   logic signed [MUL_W-1:0]   op_b;
   logic signed [PROD_W-1:0]  prod;
   logic [BASE_W-1:0]         base_u;
   logic signed [MUL_W-1:0]   base_ext;
   logic signed [CSR_W-1:0]   offset;
   logic signed [CAL_W-1:0]   cal_sum;

   always_comb begin
      unique case (ctrl.step)
         STEP_CBASE: begin
            op_a   = MUL_W'(current_raw);
            op_b   = MUL_W'(FULL_SCALE);
            offset = current_offset;
         end
         STEP_VBASE: begin
            op_a   = MUL_W'(vraw_ff);
            op_b   = MUL_W'(FULL_SCALE);
            offset = voltage_offset;
         end
         STEP_CGAIN: begin
            op_a   = cbase_ff;
            op_b   = MUL_W'(current_gain);
            offset = current_offset;
         end
         STEP_VGAIN: begin
            op_a   = vbase_ff;
            op_b   = MUL_W'(voltage_gain);
            offset = voltage_offset;
         end
         default: begin
            op_a   = '0;
            op_b   = '0;
            offset = '0;
         end
      endcase
   end

   assign prod      = op_a * op_b;
   assign base_u    = prod[RAW_SHIFT+BASE_W-1:RAW_SHIFT];
   assign base_ext  = MUL_W'(base_u);
   assign cal_sum   = prod[PROD_W-1:GAIN_SHIFT] + CAL_W'(offset);
   assign cal_value = saturate(cal_sum);

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         unique case (ctrl.step)
            STEP_CBASE: begin
               cbase_ff <= base_ext - MUL_W'(MID_SCALE);
               vraw_ff  <= voltage_raw;
            end
            STEP_VBASE: begin
               vbase_ff <= base_ext;
            end
            STEP_CGAIN: begin
               current_ff <= cal_value;
            end
            STEP_VGAIN: begin
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== src/cam_window.sv =====
// ----------------------------------------------------------------------------
// cam_window
// Ring window of scaled currents in a synchronous memory, with running sum.
// Entries not yet written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module cam_window #(
   parameter int WINDOW_LENGTH = cam_pkg::DEFAULT_WINDOW_LENGTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cam_pkg::win_ctrl_type                 ctrl,
   input  logic signed [cam_pkg::OUT_W-1:0]      wr_value,
   output logic signed [cam_pkg::OUT_W-1:0]      filtered
);
   import cam_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_LENGTH);
   localparam int SUM_W = OUT_W + IDX_W;

   logic signed [OUT_W-1:0]   mem [WINDOW_LENGTH];
   logic [WINDOW_LENGTH-1:0]  valid_ff;
   logic signed [OUT_W-1:0]   rd_data_ff;
   logic                      rd_valid_ff;
   logic [IDX_W-1:0]          slot_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [OUT_W-1:0]   old_value;

   assign old_value = rd_valid_ff ? rd_data_ff : '0;
   assign sum_in    = sum_ff - SUM_W'(old_value) + SUM_W'(wr_value);
   assign filtered  = sum_ff[SUM_W-1:IDX_W];

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[slot_ff];
      end
      if (ctrl.wr_en) begin
         mem[slot_ff] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         slot_ff     <= '0;
         sum_ff      <= '0;
      end else begin
         if (ctrl.rd_en) begin
            rd_valid_ff <= valid_ff[slot_ff];
         end
         if (ctrl.wr_en) begin
            valid_ff[slot_ff] <= 1'b1;
            slot_ff           <= slot_ff + 1'b1;
            sum_ff            <= sum_in;
         end
      end
   end

endmodule

// ===== src/calibrated_adc_moving_average.sv =====
// ----------------------------------------------------------------------------
// calibrated_adc_moving_average
// Steps: request transfer in ST_IDLE, then ST_VBASE, ST_CGAIN and ST_VGAIN;
// the result register loads in ST_VGAIN once it is free. A new pair is taken
// only in ST_IDLE; the single shared multiplier does two base conversions and two gain multiplies per pair.
// Reset: synchronous; gains return to unity, offsets to zero, window cleared.
// ----------------------------------------------------------------------------
module calibrated_adc_moving_average #(
   parameter int WINDOW_LENGTH = cam_pkg::DEFAULT_WINDOW_LENGTH
) (
   input  logic                              clock,
   input  logic                              reset,
   cam_req_if.sink                           req_chan,
   cam_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [cam_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cam_pkg::CSR_W-1:0]         csr_wdata
);
   import cam_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VBASE,
      ST_CGAIN,
      ST_VGAIN
   } state_type;

   state_type                 state_ff;
   logic [CSR_W-1:0]          cgain_ff;
   logic [CSR_W-1:0]          vgain_ff;
   logic signed [CSR_W-1:0]   coffset_ff;
   logic signed [CSR_W-1:0]   voffset_ff;

   logic                      rsp_valid_ff;
   logic signed [OUT_W-1:0]   rsp_cur_ff;
   logic signed [OUT_W-1:0]   rsp_vol_ff;
   logic signed [OUT_W-1:0]   rsp_filt_ff;

   calc_ctrl_type             calc_ctrl;
   win_ctrl_type              win_ctrl;
   logic                      req_xfer;
   logic                      rsp_free;
   logic signed [OUT_W-1:0]   cal_value;
   logic signed [OUT_W-1:0]   current_ff;
   logic signed [OUT_W-1:0]   filtered;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      calc_ctrl.en   = 1'b0;
      calc_ctrl.step = STEP_CBASE;
      win_ctrl.rd_en = 1'b0;
      win_ctrl.wr_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            calc_ctrl.en   = req_xfer;
            calc_ctrl.step = STEP_CBASE;
            win_ctrl.rd_en = req_xfer;
         end
         ST_VBASE: begin
            calc_ctrl.en   = 1'b1;
            calc_ctrl.step = STEP_VBASE;
         end
         ST_CGAIN: begin
            calc_ctrl.en   = 1'b1;
            calc_ctrl.step = STEP_CGAIN;
            win_ctrl.wr_en = 1'b1;
         end
         ST_VGAIN: begin
            calc_ctrl.en   = 1'b1;
            calc_ctrl.step = STEP_VGAIN;
         end
         default: begin
         end
      endcase
   end

   cam_calib u_calib (
      .clock          (clock),
      .ctrl           (calc_ctrl),
      .current_raw    (req_chan.current_raw),
      .voltage_raw    (req_chan.voltage_raw),
      .current_gain   (cgain_ff),
      .voltage_gain   (vgain_ff),
      .current_offset (coffset_ff),
      .voltage_offset (voffset_ff),
      .cal_value      (cal_value),
      .current_ff     (current_ff)
   );

   cam_window #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (win_ctrl),
      .wr_value (cal_value),
      .filtered (filtered)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cgain_ff   <= GAIN_RESET;
         vgain_ff   <= GAIN_RESET;
         coffset_ff <= OFFSET_RESET;
         voffset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CURRENT_GAIN:   cgain_ff   <= csr_wdata;
            CSR_VOLTAGE_GAIN:   vgain_ff   <= csr_wdata;
            CSR_CURRENT_OFFSET: coffset_ff <= csr_wdata;
            CSR_VOLTAGE_OFFSET: voffset_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready && !(state_ff == ST_VGAIN && rsp_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff <= ST_VBASE;
               end
            end
            ST_VBASE: begin
               state_ff <= ST_CGAIN;
            end
            ST_CGAIN: begin
               state_ff <= ST_VGAIN;
            end
            ST_VGAIN: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cur_ff   <= current_ff;
                  rsp_vol_ff   <= cal_value;
                  rsp_filt_ff  <= filtered;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.current_scaled   = rsp_cur_ff;
   assign rsp_chan.voltage_scaled   = rsp_vol_ff;
   assign rsp_chan.current_filtered = rsp_filt_ff;

endmodule
